### design/lgsf_pkg.sv
package lgsf_pkg;

  // Width of a node index as it travels on the channels.
  localparam int unsigned IDX_W = 10;

  // Width of the running tree edge count.
  localparam int unsigned CNT_W = 10;

  // Width of the node_count register.
  localparam int unsigned NCNT_W = 11;

  // Value of node_count after reset.
  localparam logic [NCNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

endpackage

### design/lgsf_ent_if.sv
interface lgsf_ent_if;

  logic                          valid;
  logic                          ready;
  logic [lgsf_pkg::IDX_W-1:0]    row_index;
  logic [lgsf_pkg::IDX_W-1:0]    col_index;
  logic                          last_entry;

  modport source (
    output valid, row_index, col_index, last_entry,
    input  ready
  );

  modport sink (
    input  valid, row_index, col_index, last_entry,
    output ready
  );

endinterface

### design/lgsf_res_if.sv
interface lgsf_res_if;

  logic                          valid;
  logic                          ready;
  logic                          edge_taken;
  logic [lgsf_pkg::IDX_W-1:0]    tree_row;
  logic [lgsf_pkg::IDX_W-1:0]    tree_col;
  logic [lgsf_pkg::CNT_W-1:0]    tree_edge_count;
  logic                          range_error;
  logic                          done_res;

  modport source (
    output valid, edge_taken, tree_row, tree_col, tree_edge_count, range_error, done_res,
    input  ready
  );

  modport sink (
    input  valid, edge_taken, tree_row, tree_col, tree_edge_count, range_error, done_res,
    output ready
  );

endinterface

### design/lower_graph_spanning_forest.sv
// Spanning forest of the lower graph of a sparse symmetric pattern.
// Entries arrive on ent_i as (row_index, col_index, last_entry) transactions in
// row-major order; every entry yields exactly one transaction on res_o. An entry
// with column below row is an edge, and it is reported as a tree edge when it
// joins two components of the union-find root table kept in a single memory.
// The node_count register (cfg_we_i / cfg_wdata_i) sets the range check.
// Flow: an entry that is out of range or not below the diagonal goes from
// IDLE to EMIT, where its result is loaded into the output register, and the
// block then returns to IDLE for the next entry. An edge runs the root search
// of its row and then of its column in FIND, with a HALF step for every
// path-halving hop, because each hop needs two dependent reads through the
// single read port of the root memory; its result is then loaded in EMIT.
// Only one entry is in work at once.
// Reset and every last entry start a clearing pass that rewrites the DEPTH
// table entries to identity, one per cycle; ent_i is not ready during it,
// while configuration writes are still taken.
// The result sits in an output register, so a new entry is taken while the
// previous result waits; if res_o stalls, the next result waits in the block
// and ent_i stays low until the output register frees up.
module lower_graph_spanning_forest #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lgsf_pkg::NCNT_W-1:0]    cfg_wdata_i,
  lgsf_ent_if.sink                       ent_i,
  lgsf_res_if.source                     res_o
);

  // Only 10-bit indices can reach the table, so it never needs more entries.
  localparam int unsigned IDX_SPAN = 1 << lgsf_pkg::IDX_W;
  localparam int unsigned DEPTH    = (MAX_NODES < IDX_SPAN) ? MAX_NODES : IDX_SPAN;
  localparam int unsigned AW       = $clog2(DEPTH);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_FIND = 3'd2;
  localparam logic [2:0] ST_HALF = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                       state_q, state_d;
  logic [lgsf_pkg::NCNT_W-1:0]      node_count_q;
  logic [lgsf_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]                    clr_q, clr_d;
  logic                             side_q, side_d;
  logic                             ov_q, ov_d;

  logic [AW-1:0]                    x_q, x_d;
  logic [AW-1:0]                    ra_q, ra_d;
  logic [lgsf_pkg::IDX_W-1:0]       row_q, row_d;
  logic [lgsf_pkg::IDX_W-1:0]       col_q, col_d;
  logic                             last_q, last_d;
  logic                             taken_q, taken_d;
  logic                             err_q, err_d;

  logic                             o_taken_q;
  logic [lgsf_pkg::IDX_W-1:0]       o_row_q;
  logic [lgsf_pkg::IDX_W-1:0]       o_col_q;
  logic [lgsf_pkg::CNT_W-1:0]       o_cnt_q;
  logic                             o_err_q;
  logic                             o_done_q;
  logic                             o_load;

  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic [AW-1:0]                    mem_wdata;
  logic [AW-1:0]                    mem_raddr;
  logic [AW-1:0]                    mem_rdata;

  logic                             ent_acc;
  logic                             oob;

  lgsf_root_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_root_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign ent_i.ready = (state_q == ST_IDLE);
  assign ent_acc     = ent_i.valid && ent_i.ready;

  // An index is out of range when it reaches node_count or the table size.
  assign oob = ({1'b0, ent_i.row_index} >= node_count_q) ||
               ({1'b0, ent_i.col_index} >= node_count_q) ||
               (32'(ent_i.row_index) >= MAX_NODES) ||
               (32'(ent_i.col_index) >= MAX_NODES);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    clr_d     = clr_q;
    side_d    = side_q;
    x_d       = x_q;
    ra_d      = ra_q;
    row_d     = row_q;
    col_d     = col_q;
    last_d    = last_q;
    taken_d   = taken_q;
    err_d     = err_q;
    o_load    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = x_q;
    mem_wdata = mem_rdata;
    mem_raddr = x_q;

    case (state_q)
      ST_CLR: begin
        // One identity entry per cycle.
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // The read for the row's root search starts with the transaction.
        mem_raddr = ent_i.row_index[AW-1:0];
        if (ent_acc) begin
          row_d   = ent_i.row_index;
          col_d   = ent_i.col_index;
          last_d  = ent_i.last_entry;
          taken_d = 1'b0;
          err_d   = oob;
          x_d     = ent_i.row_index[AW-1:0];
          side_d  = 1'b0;
          if (!oob && (ent_i.col_index < ent_i.row_index)) begin
            state_d = ST_FIND;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end

      ST_FIND: begin
        // mem_rdata is the parent of x_q.
        if (mem_rdata != x_q) begin
          mem_raddr = mem_rdata;
          state_d   = ST_HALF;
        end else if (!side_q) begin
          ra_d      = x_q;
          x_d       = col_q[AW-1:0];
          mem_raddr = col_q[AW-1:0];
          side_d    = 1'b1;
        end else begin
          if (ra_q != x_q) begin
            // Hang the larger root under the smaller one.
            mem_we    = 1'b1;
            mem_waddr = (ra_q < x_q) ? x_q : ra_q;
            mem_wdata = (ra_q < x_q) ? ra_q : x_q;
            cnt_d     = cnt_q + 1'b1;
            taken_d   = 1'b1;
          end
          state_d = ST_EMIT;
        end
      end

      ST_HALF: begin
        // mem_rdata is the grandparent: point x at it and continue from there.
        mem_we    = 1'b1;
        mem_waddr = x_q;
        mem_wdata = mem_rdata;
        mem_raddr = mem_rdata;
        x_d       = mem_rdata;
        state_d   = ST_FIND;
      end

      ST_EMIT: begin
        if (!ov_q || res_o.ready) begin
          o_load = 1'b1;
          if (last_q) begin
            cnt_d   = '0;
            clr_d   = '0;
            state_d = ST_CLR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (res_o.ready) begin
      ov_d = 1'b0;
    end
    if (o_load) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      node_count_q <= lgsf_pkg::NODE_COUNT_RESET;
      cnt_q        <= '0;
      clr_q        <= '0;
      side_q       <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      side_q  <= side_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    ra_q    <= ra_d;
    row_q   <= row_d;
    col_q   <= col_d;
    last_q  <= last_d;
    taken_q <= taken_d;
    err_q   <= err_d;
    if (o_load) begin
      o_taken_q <= taken_q;
      o_row_q   <= taken_q ? row_q : '0;
      o_col_q   <= taken_q ? col_q : '0;
      o_cnt_q   <= cnt_q;
      o_err_q   <= err_q;
      o_done_q  <= last_q;
    end
  end

  assign res_o.valid           = ov_q;
  assign res_o.edge_taken      = o_taken_q;
  assign res_o.tree_row        = o_row_q;
  assign res_o.tree_col        = o_col_q;
  assign res_o.tree_edge_count = o_cnt_q;
  assign res_o.range_error     = o_err_q;
  assign res_o.done_res        = o_done_q;

endmodule

### design/lgsf_root_ram.sv
module lgsf_root_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [AW-1:0] rdata_o
);

  logic [AW-1:0] mem_q [DEPTH];
  logic [AW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; a read at the address being written returns the old entry.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

// Checks lower_graph_spanning_forest against a predictor of the spanning forest.
// Matrix entries go in on ent_i and one result per entry comes back on res_o.
// The predictor keeps its own root table, edge count and node limit.
// Each accepted entry produces one expected result, and the checker compares
// every accepted result with the oldest expected one, field by field.
module testbench;

  localparam int unsigned IDX_W  = lgsf_pkg::IDX_W;
  localparam int unsigned CNT_W  = lgsf_pkg::CNT_W;
  localparam int unsigned NCNT_W = lgsf_pkg::NCNT_W;

  localparam int NODES        = 1024;
  localparam int LIMIT_CYCLES = 3000000;
  // Edges in range and below the diagonal that each random phase aims for.
  localparam int PHASE_EDGES  = 480;

  // One expected or observed result transaction.
  typedef struct packed {
    logic             edge_taken;
    logic [IDX_W-1:0] tree_row;
    logic [IDX_W-1:0] tree_col;
    logic [CNT_W-1:0] tree_edge_count;
    logic             range_error;
    logic             done_res;
  } forest_result_t;

  // One nonzero of a matrix, as the stimulus generator lays it out.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } nonzero_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [NCNT_W-1:0] cfg_wdata;

  lgsf_ent_if ent_bus ();
  lgsf_res_if res_bus ();

  lower_graph_spanning_forest i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .ent_i       (ent_bus),
    .res_o       (res_bus)
  );

  // Predictor state: the union-find table, the running tree edge count and
  // the node_count register as the block should hold it.
  logic [IDX_W-1:0]  parent_of [NODES];
  logic [CNT_W-1:0]  tree_edges;
  logic [NCNT_W-1:0] node_limit;

  forest_result_t pending_results [$];

  int mismatch_count;
  int edges_offered;
  int cycle_count;
  int tx_idle_pct;
  int rx_idle_pct;
  // Cycles that the receiver still has to hold ready low.
  int rx_hold;

  // 12 ns clock, low first so that the first rising edge comes at 6 ns.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // The run must end on its own long before this; a hang is a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("lower_graph_spanning_forest verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Back to a forest of single nodes, as after reset or a last entry.
  function automatic void clear_forest();
    for (int i = 0; i < NODES; i++) begin
      parent_of[i] = IDX_W'(i);
    end
    tree_edges = '0;
  endfunction

  // Root search with path halving: each visited node is hooked to its
  // grandparent on the way up. The outcome does not depend on the halving,
  // but keeping it holds the table in the same shape as the block's.
  function automatic logic [IDX_W-1:0] find_component(logic [IDX_W-1:0] node);
    logic [IDX_W-1:0] up;
    while (parent_of[node] != node) begin
      up = parent_of[parent_of[node]];
      parent_of[node] = up;
      node = up;
    end
    return node;
  endfunction

  // Works out the result of one entry and advances the forest. An edge joins
  // two components by hanging the larger root under the smaller one.
  function automatic forest_result_t predict_entry(logic [IDX_W-1:0] row,
                                                   logic [IDX_W-1:0] col,
                                                   logic last);
    forest_result_t   res;
    logic [NCNT_W-1:0] lim;
    logic [IDX_W-1:0] root_row;
    logic [IDX_W-1:0] root_col;
    res = '0;
    // Values above the table size behave as the full table.
    lim = (node_limit > NCNT_W'(NODES)) ? NCNT_W'(NODES) : node_limit;
    if ({1'b0, row} >= lim || {1'b0, col} >= lim) begin
      res.range_error = 1'b1;
    end else if (col < row) begin
      edges_offered++;
      root_row = find_component(row);
      root_col = find_component(col);
      if (root_row != root_col) begin
        if (root_row < root_col) begin
          parent_of[root_col] = root_row;
        end else begin
          parent_of[root_row] = root_col;
        end
        tree_edges     = tree_edges + 1'b1;
        res.edge_taken = 1'b1;
        res.tree_row   = row;
        res.tree_col   = col;
      end
    end
    res.tree_edge_count = tree_edges;
    res.done_res        = last;
    if (last) begin
      clear_forest();
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------

  // Ready changes only at the falling edge. A pending hold-off wins over the
  // random stalls.
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        res_bus.ready <= 1'b0;
        rx_hold--;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic check_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Every result transaction is matched with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    forest_result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("edge_taken", IDX_W'(want.edge_taken), IDX_W'(res_bus.edge_taken));
        check_field("tree_row", want.tree_row, res_bus.tree_row);
        check_field("tree_col", want.tree_col, res_bus.tree_col);
        check_field("tree_edge_count", want.tree_edge_count, res_bus.tree_edge_count);
        check_field("range_error", IDX_W'(want.range_error), IDX_W'(res_bus.range_error));
        check_field("done_res", IDX_W'(want.done_res), IDX_W'(res_bus.done_res));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Every stimulus task begins at a falling edge with its first drive, and a
  // task that sends returns at the rising edge of the handshake. Valid is
  // therefore left high after a transaction, and whatever comes next either
  // raises it again for the next entry or lowers it, never both in one step.
  task automatic send_entry(int row, int col, bit last);
    @(negedge clk_i);
    // Each cycle the sender may choose to idle before offering the entry.
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      ent_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    ent_bus.valid      <= 1'b1;
    ent_bus.row_index  <= IDX_W'(row);
    ent_bus.col_index  <= IDX_W'(col);
    ent_bus.last_entry <= last;
    do begin
      @(posedge clk_i);
    end while (!ent_bus.ready);
    pending_results.push_back(predict_entry(IDX_W'(row), IDX_W'(col), last));
  endtask

  // Stop offering entries and wait until every expected result is back.
  task automatic drain_results();
    @(negedge clk_i);
    ent_bus.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // node_count is only written with nothing in flight. Each entry has a
  // result, so an empty queue means the block is idle apart from a clearing
  // pass, which does not block configuration writes.
  task automatic write_node_count(int value);
    drain_results();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= NCNT_W'(value);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    node_limit = NCNT_W'(value);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // The reset value of node_count covers the whole table, so the extreme
  // indices and alternating bit patterns are all in range here.
  task automatic test_default_range();
    send_entry(1023, 0, 1'b0);
    send_entry(1023, 1022, 1'b0);
    send_entry(682, 341, 1'b0);
    send_entry(341, 682, 1'b0);
    send_entry(1023, 1023, 1'b0);
    send_entry(512, 0, 1'b1);
  endtask

  // A small graph with cycles, a diagonal entry and indices past the limit.
  // The entry after the last one checks that the forest was cleared.
  task automatic test_small_forest();
    write_node_count(6);
    send_entry(1, 0, 1'b0);
    send_entry(2, 1, 1'b0);
    send_entry(2, 0, 1'b0);
    send_entry(3, 3, 1'b0);
    send_entry(3, 6, 1'b0);
    send_entry(6, 0, 1'b0);
    send_entry(4, 2, 1'b0);
    send_entry(5, 4, 1'b0);
    send_entry(5, 3, 1'b0);
    send_entry(5, 5, 1'b1);
    send_entry(1, 0, 1'b1);
  endtask

  // node_count of zero flags everything, one allows only node 0, and any
  // value above the table size acts as the full table.
  task automatic test_node_count_limits();
    write_node_count(0);
    send_entry(0, 0, 1'b0);
    send_entry(1, 0, 1'b1);
    write_node_count(1);
    send_entry(0, 0, 1'b0);
    send_entry(1, 0, 1'b1);
    write_node_count(2047);
    send_entry(1023, 1, 1'b1);
  endtask

  // Narrowing the limit inside a matrix keeps the forest; only the range
  // check follows the new value. The final cycle test depends on that.
  task automatic test_mid_matrix_write();
    write_node_count(8);
    send_entry(3, 1, 1'b0);
    send_entry(5, 3, 1'b0);
    write_node_count(4);
    send_entry(5, 1, 1'b0);
    send_entry(3, 2, 1'b0);
    write_node_count(8);
    send_entry(5, 2, 1'b0);
    send_entry(7, 6, 1'b1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the block fills up and stops taking entries. Afterwards the sender
  // waits for every result before the matrix is finished.
  task automatic test_output_hold_off();
    write_node_count(32);
    @(negedge clk_i);
    rx_hold = 400;
    for (int i = 1; i <= 16; i++) begin
      send_entry(i, $urandom_range(0, i - 1), 1'b0);
    end
    drain_results();
    send_entry(31, 17, 1'b0);
    send_entry(31, 31, 1'b1);
  endtask

  // One matrix in row-major order: ascending rows, ascending columns within
  // a row, mostly below the diagonal. Large limits use sparse rows so that a
  // matrix stays short. Now and then a stray entry with arbitrary indices is
  // slipped in, sometimes marked last, which breaks the matrix apart.
  task automatic send_random_matrix();
    nonzero_t matrix [$];
    int       sel;
    int       ncfg;
    int       lim;
    int       span;
    int       r;
    int       c;
    int       k;
    sel = $urandom_range(0, 19);
    case (sel)
      0: ncfg = 0;
      1: ncfg = 1;
      2: ncfg = NODES;
      3: ncfg = $urandom_range(NODES + 1, 2047);
      default: ncfg = $urandom_range(2, 40);
    endcase
    write_node_count(ncfg);
    lim  = (ncfg > NODES) ? NODES : ncfg;
    span = (lim == 0) ? 64 : lim;
    r = 0;
    while (r < span) begin
      k = $urandom_range(0, 3);
      c = $urandom_range(0, r);
      for (int j = 0; j < k && c < span; j++) begin
        matrix.push_back('{row: IDX_W'(r), col: IDX_W'(c)});
        c += $urandom_range(1, span / 4 + 1);
      end
      r += (span > 48) ? $urandom_range(1, span / 16) : 1;
    end
    if (matrix.size() == 0) begin
      matrix.push_back('{row: IDX_W'(span - 1), col: '0});
    end
    foreach (matrix[i]) begin
      if ($urandom_range(99) < 4) begin
        send_entry($urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 49) == 0);
      end
      send_entry(matrix[i].row, matrix[i].col, i == matrix.size() - 1);
    end
  endtask

  task automatic test_random_matrices();
    int goal;
    goal = edges_offered + PHASE_EDGES;
    while (edges_offered < goal) begin
      send_random_matrix();
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    ent_bus.valid      = 1'b0;
    ent_bus.row_index  = '0;
    ent_bus.col_index  = '0;
    ent_bus.last_entry = 1'b0;
    mismatch_count     = 0;
    edges_offered      = 0;
    cycle_count        = 0;
    rx_hold            = 0;
    tx_idle_pct        = 20;
    rx_idle_pct        = 79;
    node_limit         = lgsf_pkg::NODE_COUNT_RESET;
    clear_forest();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with a slow receiver.
    test_default_range();
    test_small_forest();
    test_node_count_limits();
    test_mid_matrix_write();

    // The hold-off works best with a sender that never pauses.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_hold_off();

    // Random part in three pacing phases.
    tx_idle_pct = 20;
    rx_idle_pct = 79;
    test_random_matrices();
    tx_idle_pct = 79;
    rx_idle_pct = 20;
    test_random_matrices();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_matrices();

    drain_results();
    // Give any stray result time to show up.
    repeat (50) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("lower_graph_spanning_forest verification clean");
    end else begin
      $display("lower_graph_spanning_forest verification failed");
    end
    $finish;
  end

endmodule
